// ----- sv/first_fit_heap_allocator_defines.svh -----
// assertion macros for the first-fit heap allocator
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// consequent must hold in the same cycle
`define FFHA_ASSERT_NOW(label, cond, expect_now) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |-> (expect_now)) else $error("allocator check failed");

// consequent must hold in the cycle after the antecedent
`define FFHA_ASSERT_NEXT(label, cond, expect_next) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> (expect_next)) else $error("allocator check failed");

`endif

// ----- sv/ffha_pkg.sv -----
// package: types, constants and codes of the first-fit heap allocator
package ffha_pkg;

    localparam int unsigned MAX_BLOCKS   = 64;
    localparam int unsigned HEAP_BYTES   = 65536;
    localparam int unsigned HEADER_BYTES = 24;

    localparam int unsigned SIZE_W = 17;
    localparam int unsigned IDX_W  = $clog2(MAX_BLOCKS);
    localparam int unsigned CNT_W  = $clog2(MAX_BLOCKS + 1);

    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        ST_OK        = 2'd0,
        ST_ZERO      = 2'd1,
        ST_OOM       = 2'd2,
        ST_BAD_INDEX = 2'd3
    } status_t;

    typedef struct packed
    {
        opcode_t           opcode;
        logic [SIZE_W-1:0] request_size;
        logic [IDX_W-1:0]  block_index;
    } alloc_req_t;

    typedef struct packed
    {
        status_t           status;
        logic [SIZE_W-1:0] payload_address;
        logic [IDX_W-1:0]  granted_index;
    } alloc_rsp_t;

    typedef struct packed
    {
        logic              free;
        logic [SIZE_W-1:0] start;
        logic [SIZE_W-1:0] size;
    } blk_entry_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_APPEND,
        S_FREE,
        S_DONE
    } fsm_state_t;

    typedef struct packed
    {
        logic load;
        logic scan_init;
        logic scan_step;
        logic take_hit;
        logic do_append;
        logic do_free;
        logic res_zero;
        logic res_bad;
    } dp_cmd_t;

    typedef struct packed
    {
        logic is_free;
        logic size_zero;
        logic bad_index;
        logic count_zero;
        logic hit;
        logic scan_end;
    } dp_status_t;

endpackage

// ----- sv/ffha_datapath.sv -----
// datapath: block table memory, break and count registers, scan pointers, result register
`include "first_fit_heap_allocator_defines.svh"

module ffha_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  ffha_pkg::dp_cmd_t    cmd,
    input  ffha_pkg::alloc_req_t req,
    output ffha_pkg::dp_status_t status,
    output ffha_pkg::alloc_rsp_t rsp
);
    import ffha_pkg::*;

    blk_entry_t mem [MAX_BLOCKS];
    blk_entry_t rd_data_reg;
    blk_entry_t wr_data;
    logic       wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;

    alloc_req_t req_reg;
    alloc_rsp_t rsp_reg, rsp_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SIZE_W-1:0] break_reg, break_next;
    logic [CNT_W-1:0]  scan_idx_reg;
    logic [IDX_W-1:0]  chk_idx_reg;
    logic              chk_valid_reg;

    logic [SIZE_W:0]   append_end;
    logic              append_fits;
    logic              free_last;
    logic [SIZE_W-1:0] hdr;

    assign hdr = SIZE_W'(HEADER_BYTES);

    // request latch
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
    end

    // table memory, one write and one registered read per cycle
    assign rd_addr = cmd.scan_step ? scan_idx_reg[IDX_W-1:0] : req_reg.block_index;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // scan pointers: read index runs one ahead of the checked index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg  <= '0;
            chk_idx_reg   <= '0;
            chk_valid_reg <= 1'b0;
        end
        else if (cmd.scan_init)
        begin
            scan_idx_reg  <= '0;
            chk_idx_reg   <= '0;
            chk_valid_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg  <= scan_idx_reg + CNT_W'(1);
            chk_idx_reg   <= scan_idx_reg[IDX_W-1:0];
            chk_valid_reg <= (scan_idx_reg < count_reg);
        end
    end

    assign append_end  = {1'b0, break_reg} + {1'b0, hdr} + {1'b0, req_reg.request_size};
    assign append_fits = (count_reg < CNT_W'(MAX_BLOCKS))
                      && (append_end <= (SIZE_W+1)'(HEAP_BYTES));
    assign free_last   = ({1'b0, req_reg.block_index} + CNT_W'(1)) == count_reg;

    always_comb
    begin
        count_next = count_reg;
        break_next = break_reg;
        rsp_next   = rsp_reg;
        wr_en      = 1'b0;
        wr_addr    = chk_idx_reg;
        wr_data    = rd_data_reg;
        if (cmd.res_zero)
        begin
            rsp_next = '{status: ST_ZERO, payload_address: '0, granted_index: '0};
        end
        if (cmd.res_bad)
        begin
            rsp_next = '{status: ST_BAD_INDEX, payload_address: '0,
                         granted_index: req_reg.block_index};
        end
        if (cmd.take_hit)
        begin
            wr_en        = 1'b1;
            wr_addr      = chk_idx_reg;
            wr_data.free = 1'b0;
            rsp_next     = '{status: ST_OK, payload_address: rd_data_reg.start + hdr,
                             granted_index: chk_idx_reg};
        end
        if (cmd.do_append)
        begin
            if (append_fits)
            begin
                wr_en      = 1'b1;
                wr_addr    = count_reg[IDX_W-1:0];
                wr_data    = '{free: 1'b0, start: break_reg, size: req_reg.request_size};
                count_next = count_reg + CNT_W'(1);
                break_next = append_end[SIZE_W-1:0];
                rsp_next   = '{status: ST_OK, payload_address: break_reg + hdr,
                               granted_index: count_reg[IDX_W-1:0]};
            end
            else
            begin
                rsp_next = '{status: ST_OOM, payload_address: '0, granted_index: '0};
            end
        end
        if (cmd.do_free)
        begin
            rsp_next = '{status: ST_OK, payload_address: rd_data_reg.start + hdr,
                         granted_index: req_reg.block_index};
            if (free_last)
            begin
                break_next = rd_data_reg.start;
                count_next = {1'b0, req_reg.block_index};
            end
            else
            begin
                wr_en        = 1'b1;
                wr_addr      = req_reg.block_index;
                wr_data.free = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            break_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            break_reg <= break_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp = rsp_reg;

    assign status.is_free    = (req_reg.opcode == OP_FREE);
    assign status.size_zero  = (req_reg.request_size == '0);
    assign status.bad_index  = ({1'b0, req_reg.block_index} >= count_reg);
    assign status.count_zero = (count_reg == '0);
    assign status.hit        = chk_valid_reg && rd_data_reg.free
                            && (rd_data_reg.size >= req_reg.request_size);
    assign status.scan_end   = chk_valid_reg
                            && (({1'b0, chk_idx_reg} + CNT_W'(1)) == count_reg);

    `FFHA_ASSERT_NOW(count_in_range, 1'b1, count_reg <= CNT_W'(MAX_BLOCKS))
    `FFHA_ASSERT_NOW(break_in_range, 1'b1, {1'b0, break_reg} <= (SIZE_W+1)'(HEAP_BYTES))
    `FFHA_ASSERT_NEXT(append_grows, cmd.do_append && append_fits,
        count_reg == $past(count_reg) + CNT_W'(1))

endmodule

// ----- sv/ffha_ctrl.sv -----
// controller: sequencing state machine for decode, table scan, append and free
`include "first_fit_heap_allocator_defines.svh"

module ffha_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  ffha_pkg::dp_status_t status,
    output ffha_pkg::dp_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);
    import ffha_pkg::*;

    fsm_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (status.is_free)
                begin
                    state_next = status.bad_index ? S_DONE : S_FREE;
                end
                else if (status.size_zero)
                begin
                    state_next = S_DONE;
                end
                else if (status.count_zero)
                begin
                    state_next = S_APPEND;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (status.hit)
                begin
                    state_next = S_DONE;
                end
                else if (status.scan_end)
                begin
                    state_next = S_APPEND;
                end
            end
            S_APPEND: state_next = S_DONE;
            S_FREE:   state_next = S_DONE;
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            S_DECODE:
            begin
                cmd.scan_init = 1'b1;
                cmd.res_zero  = !status.is_free && status.size_zero;
                cmd.res_bad   = status.is_free && status.bad_index;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                cmd.take_hit  = status.hit;
            end
            S_APPEND: cmd.do_append = 1'b1;
            S_FREE:   cmd.do_free   = 1'b1;
            S_DONE:   done          = 1'b1;
            default:  busy          = 1'b1;
        endcase
    end

    `FFHA_ASSERT_NEXT(one_result, done, !done && !busy)
    `FFHA_ASSERT_NEXT(accept_decodes, start && !busy, state_reg == S_DECODE)
    `FFHA_ASSERT_NEXT(hit_finishes, state_reg == S_SCAN && status.hit, done)

endmodule

// ----- sv/first_fit_heap_allocator.sv -----
// top level: first-fit heap allocator, controller plus table datapath
//
//   channel   dir   handshake                     payload
//   request   in    start, taken when busy is low alloc_req_t (opcode, size, index)
//   result    out   done, one-cycle strobe        alloc_rsp_t (status, address, index)
//
// zero-size and bad-index requests: decode state, then the result state
// free: decode, free, result; allocate: decode, scan to the first fit, else append
//   (an empty table skips the scan), then result; one table read per cycle
// busy stays high from the cycle after a request until the result cycle ends, so the
//   next request is taken in the cycle after the result at the earliest
// the receiver cannot stall; reset clears the block count and the break

module first_fit_heap_allocator
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  ffha_pkg::alloc_req_t req,
    output logic                 busy,
    output logic                 done,
    output ffha_pkg::alloc_rsp_t rsp
);
    import ffha_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    ffha_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    ffha_datapath u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .req    (req),
        .status (status),
        .rsp    (rsp)
    );

endmodule

// ----- test/first_fit_heap_allocator_tb.sv -----
// testbench: first-fit heap allocator, directed and random requests checked against a predictor
`timescale 1ns / 1ps

module first_fit_heap_allocator_tb;

    import ffha_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES  = MAX_BLOCKS + 16;
    localparam int unsigned RANDOM_ITEMS   = 1230;
    localparam int unsigned PHASE_ITEMS    = 150;
    localparam int unsigned SIZE_MAX       = (1 << SIZE_W) - 1;
    localparam int unsigned INDEX_MAX      = MAX_BLOCKS - 1;

    logic       clk   = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    alloc_req_t req   = '0;
    logic       busy;
    logic       done;
    alloc_rsp_t rsp;

    logic [SIZE_W-1:0] blk_size  [MAX_BLOCKS];
    logic [SIZE_W-1:0] blk_start [MAX_BLOCKS];
    logic              blk_free  [MAX_BLOCKS];
    int unsigned       blk_count = 0;
    int unsigned       heap_top  = 0;

    alloc_rsp_t  pending_results [$];
    int unsigned error_count  = 0;
    int unsigned stall_cycles = 0;
    bit          gaps_enabled = 1'b1;

    first_fit_heap_allocator u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic alloc_rsp_t predict_alloc_result(alloc_req_t item);
        alloc_rsp_t  r;
        int unsigned i;
        int unsigned idx;
        r.status          = ST_OK;
        r.payload_address = '0;
        r.granted_index   = '0;
        if (item.opcode == OP_ALLOC)
        begin
            if (item.request_size == '0)
            begin
                r.status = ST_ZERO;
                return r;
            end
            for (i = 0; i < blk_count; i++)
            begin
                if (blk_free[i] && blk_size[i] >= item.request_size)
                begin
                    blk_free[i]       = 1'b0;
                    r.payload_address = SIZE_W'(blk_start[i] + HEADER_BYTES);
                    r.granted_index   = IDX_W'(i);
                    return r;
                end
            end
            if (blk_count >= MAX_BLOCKS ||
                heap_top + HEADER_BYTES + item.request_size > HEAP_BYTES)
            begin
                r.status = ST_OOM;
                return r;
            end
            blk_start[blk_count] = SIZE_W'(heap_top);
            blk_size[blk_count]  = item.request_size;
            blk_free[blk_count]  = 1'b0;
            r.payload_address    = SIZE_W'(heap_top + HEADER_BYTES);
            r.granted_index      = IDX_W'(blk_count);
            heap_top             = heap_top + HEADER_BYTES + item.request_size;
            blk_count            = blk_count + 1;
            return r;
        end
        idx             = item.block_index;
        r.granted_index = item.block_index;
        if (idx >= blk_count)
        begin
            r.status = ST_BAD_INDEX;
            return r;
        end
        r.payload_address = SIZE_W'(blk_start[idx] + HEADER_BYTES);
        if (idx + 1 == blk_count)
        begin
            heap_top  = blk_start[idx];
            blk_count = idx;
        end
        else
        begin
            blk_free[idx] = 1'b1;
        end
        return r;
    endfunction

    task automatic issue_request(input opcode_t op, input int unsigned size,
                                 input int unsigned index);
        alloc_req_t item;
        bit         idle;
        item.opcode       = op;
        item.request_size = SIZE_W'(size);
        item.block_index  = IDX_W'(index);
        req <= item;
        do
        begin
            idle = gaps_enabled && ($urandom_range(99) < 27);
            start <= !idle;
            @(posedge clk);
        end
        while (idle || busy);
        pending_results.push_back(predict_alloc_result(item));
    endtask

    task automatic wait_results_drained();
        start <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        alloc_rsp_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, actual %p", $time, rsp);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.status !== want.status)
                begin
                    error_count++;
                    $display("%0t: status expected %s actual %s", $time,
                             want.status.name(), rsp.status.name());
                end
                if (rsp.payload_address !== want.payload_address)
                begin
                    error_count++;
                    $display("%0t: payload_address expected %0d actual %0d", $time,
                             want.payload_address, rsp.payload_address);
                end
                if (rsp.granted_index !== want.granted_index)
                begin
                    error_count++;
                    $display("%0t: granted_index expected %0d actual %0d", $time,
                             want.granted_index, rsp.granted_index);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles == WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic test_zero_size();
        issue_request(OP_ALLOC, 0, INDEX_MAX);
        issue_request(OP_ALLOC, 0, 0);
        wait_results_drained();
    endtask

    task automatic test_bad_index();
        issue_request(OP_FREE, 0, 0);
        issue_request(OP_FREE, SIZE_MAX, INDEX_MAX);
        wait_results_drained();
    endtask

    task automatic test_first_fit_and_pop();
        issue_request(OP_ALLOC, 1, 0);
        issue_request(OP_ALLOC, 16, 0);
        issue_request(OP_FREE, 0, 0);
        issue_request(OP_ALLOC, 1, 0);
        issue_request(OP_FREE, 0, 0);
        // double free of an inner block
        issue_request(OP_FREE, 0, 0);
        issue_request(OP_ALLOC, 2, 0);
        issue_request(OP_FREE, 0, 2);
        issue_request(OP_FREE, 0, 1);
        // last block already free gets popped
        issue_request(OP_FREE, 0, 0);
        issue_request(OP_FREE, 0, 1);
        wait_results_drained();
    endtask

    task automatic test_heap_limit();
        issue_request(OP_ALLOC, HEAP_BYTES, 0);
        issue_request(OP_ALLOC, SIZE_MAX, 0);
        issue_request(OP_ALLOC, HEAP_BYTES - HEADER_BYTES, 0);
        issue_request(OP_ALLOC, 1, 0);
        issue_request(OP_FREE, 0, 0);
        issue_request(OP_FREE, 0, 0);
        wait_results_drained();
    endtask

    function automatic int unsigned random_size();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 4)
            return 0;
        if (pick < 10)
            return $urandom_range(SIZE_MAX);
        if (pick < 18)
            return $urandom_range(HEAP_BYTES + 4096, 4096);
        if (pick < 60)
            return $urandom_range(256, 1);
        return $urandom_range(2048, 1);
    endfunction

    function automatic int unsigned random_index();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8 || blk_count == 0)
            return $urandom_range(INDEX_MAX);
        if (pick < 30)
            return blk_count - 1;
        return $urandom_range(blk_count - 1);
    endfunction

    task automatic test_random_traffic();
        int unsigned n;
        int unsigned alloc_pct;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            case ((n / PHASE_ITEMS) % 3)
                0:       alloc_pct = 80;
                1:       alloc_pct = 50;
                default: alloc_pct = 25;
            endcase
            gaps_enabled = !(n >= 600 && n < 800);
            if (n % 250 == 249)
                wait_results_drained();
            if ($urandom_range(99) < alloc_pct)
                issue_request(OP_ALLOC, random_size(), $urandom_range(INDEX_MAX));
            else
                issue_request(OP_FREE, $urandom_range(SIZE_MAX), random_index());
        end
        gaps_enabled = 1'b1;
        wait_results_drained();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_zero_size();
        test_bad_index();
        test_first_fit_and_pop();
        test_heap_limit();
        test_random_traffic();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
